FILE: rtl/core/mbrc_pkg.sv
package mbrc_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COUNT = 2'd2;

	localparam logic [7:0] SLAVE_ADDRESS_RST  = 8'd1;
	localparam logic [7:0] FUNCTION_CODE_RST  = 8'd3;
	localparam logic [6:0] REGISTER_COUNT_RST = 7'd1;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_CRC_BAD    = 2'd1;
	localparam logic [1:0] ST_HEADER_BAD = 2'd2;
	localparam logic [1:0] ST_LENGTH_BAD = 2'd3;

	localparam logic [7:0] POS_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
	} in_t;

	typedef struct packed {
		logic        result_kind;
		logic [6:0]  word_index;
		logic [15:0] word_value;
		logic [1:0]  status;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [7:0] function_code;
		logic [6:0] register_count;
	} cfg_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        lsb;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			lsb = c[0];
			c = {1'b0, c[15:1]};
			if (lsb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/core/mbrc_frame_core.sv
module mbrc_frame_core
	import mbrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  in_t  item,
	input  logic fire,
	output logic res_valid,
	output out_t res
);

	logic [15:0] crc_q;
	logic [7:0]  prev_q;
	logic [7:0]  pos_q;
	logic        hdr_q;

	logic [15:0] crc_new;
	logic        hdr_new;
	logic [8:0]  expected_last;
	logic [15:0] rx_crc;
	logic [7:0]  pos_off;
	logic [6:0]  k;
	logic [1:0]  st;

	always_comb begin
		expected_last = 9'd4 + {1'b0, cfg.register_count, 1'b0};
		crc_new = (pos_q != 8'd0) ? crc_feed(crc_q, prev_q) : crc_q;
		hdr_new = hdr_q;
		if (pos_q == 8'd0 && item.rx_byte != cfg.slave_address) begin
			hdr_new = 1'b1;
		end
		if (pos_q == 8'd1 && item.rx_byte != cfg.function_code) begin
			hdr_new = 1'b1;
		end
		if (pos_q == 8'd2 && item.rx_byte != {cfg.register_count, 1'b0}) begin
			hdr_new = 1'b1;
		end
		rx_crc = {item.rx_byte, prev_q};
		if (pos_q == 8'd0) begin
			st = ST_LENGTH_BAD;
		end else if (rx_crc != crc_q) begin
			st = ST_CRC_BAD;
		end else if (hdr_new || pos_q < 8'd2) begin
			st = ST_HEADER_BAD;
		end else if ({1'b0, pos_q} != expected_last) begin
			st = ST_LENGTH_BAD;
		end else begin
			st = ST_OK;
		end
		pos_off = pos_q - 8'd4;
		k = pos_off[7:1];

		res = '0;
		res_valid = 1'b0;
		if (item.end_of_frame) begin
			res_valid = 1'b1;
			res.result_kind = KIND_STATUS;
			res.status = st;
			res.last = 1'b1;
		end else if (pos_q >= 8'd4 && !pos_q[0] && k < cfg.register_count) begin
			res_valid = 1'b1;
			res.result_kind = KIND_WORD;
			res.word_index = k;
			res.word_value = {prev_q, item.rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_PRESET;
			prev_q <= 8'd0;
			pos_q <= 8'd0;
			hdr_q <= 1'b0;
		end else if (fire) begin
			if (item.end_of_frame) begin
				crc_q <= CRC_PRESET;
				prev_q <= 8'd0;
				pos_q <= 8'd0;
				hdr_q <= 1'b0;
			end else begin
				crc_q <= crc_new;
				prev_q <= item.rx_byte;
				hdr_q <= hdr_new;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.end_of_frame |=> pos_q == 8'd0 && crc_q == CRC_PRESET && !hdr_q)
		else $error("frame state not cleared after final beat");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !item.end_of_frame && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 8'd1)
		else $error("byte position did not advance");

	a_word_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == KIND_WORD |-> res.word_index < cfg.register_count)
		else $error("word index beyond register count");

endmodule

FILE: rtl/core/modbus_rtu_read_response_checker_top.sv
// an accepted byte waits in the input register and its result enters the result register when it fires
// throughput: one byte per cycle while no result waits on result_ready; the unrolled eight-step crc
// update runs in the core on its saved previous byte and crc register
// a result waiting on result_ready stalls input only when the input register is also full
// reset: config returns to address 1, function 3, one register; frame state clears
module modbus_rtu_read_response_checker_top
	import mbrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  in_t                  byte_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_t                 result_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	in_t  item_s1;
	logic valid_s2;
	out_t result_s2;

	logic advance;
	logic fire;
	logic res_valid;
	out_t res;

	assign cfg_ready = 1'b1;
	assign advance = !valid_s2 || result_ready;
	assign fire = valid_s1 && advance;
	assign byte_ready = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result_data = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= SLAVE_ADDRESS_RST;
			cfg_q.function_code <= FUNCTION_CODE_RST;
			cfg_q.register_count <= REGISTER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLAVE_ADDRESS:  cfg_q.slave_address <= cfg_data;
				CFG_FUNCTION_CODE:  cfg_q.function_code <= cfg_data;
				CFG_REGISTER_COUNT: cfg_q.register_count <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_data;
		end
	end

	mbrc_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item_s1),
		.fire      (fire),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			result_s2 <= res;
		end
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> valid_s1 && valid_s2 && !result_ready)
		else $error("input stalled without a full pipeline");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.last == (result_s2.result_kind == KIND_STATUS))
		else $error("last flag disagrees with result kind");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_ready |=> valid_s2 && $stable(result_s2))
		else $error("pending result changed under stall");

endmodule

FILE: dv/tb_modbus_rtu_read_response_checker_top.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_read_response_checker_top;
	import mbrc_pkg::*;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_HEADER,
		FR_BAD_LENGTH,
		FR_NOISE,
		FR_HUGE
	} frame_shape_e;

	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_COUNT   = 14;
	localparam int PHASE_BYTES   = 70;
	localparam int SETTLE_CYCLES = 6;

	class rtu_reply_scoreboard;
		cfg_t        regs;
		logic [15:0] crc_cur;
		logic [15:0] crc_lag;
		logic [7:0]  prev_byte;
		logic [7:0]  pos;
		logic        hdr_bad;
		out_t        due_outputs[$];
		int unsigned errors;

		function new();
			regs.slave_address  = SLAVE_ADDRESS_RST;
			regs.function_code  = FUNCTION_CODE_RST;
			regs.register_count = REGISTER_COUNT_RST;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			crc_cur   = 16'hFFFF;
			crc_lag   = 16'hFFFF;
			prev_byte = 8'd0;
			pos       = 8'd0;
			hdr_bad   = 1'b0;
		endfunction

		function logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
			logic [15:0] acc;
			acc = {crc[15:8], crc[7:0] ^ b};
			for (int n = 0; n < 8; n++) begin
				if (acc[0]) begin
					acc = (acc >> 1) ^ 16'hA001;
				end else begin
					acc = acc >> 1;
				end
			end
			return acc;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
			case (idx)
				CFG_SLAVE_ADDRESS:  regs.slave_address  = val;
				CFG_FUNCTION_CODE:  regs.function_code  = val;
				CFG_REGISTER_COUNT: regs.register_count = val[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return due_outputs.size();
		endfunction

		function void note_byte(input in_t item);
			logic [15:0] lag_n;
			logic [15:0] cur_n;
			logic        hdr;
			logic [1:0]  st;
			logic [7:0]  k;
			out_t        r;
			lag_n = crc_cur;
			cur_n = crc_cur;
			if (pos >= 8'd1) begin
				cur_n = crc_next(crc_cur, prev_byte);
			end
			hdr = hdr_bad;
			if (pos == 8'd0 && item.rx_byte != regs.slave_address) begin
				hdr = 1'b1;
			end
			if (pos == 8'd1 && item.rx_byte != regs.function_code) begin
				hdr = 1'b1;
			end
			if (pos == 8'd2 && item.rx_byte != {regs.register_count, 1'b0}) begin
				hdr = 1'b1;
			end
			if (item.end_of_frame) begin
				if (pos == 8'd0) begin
					st = ST_LENGTH_BAD;
				end else if ({item.rx_byte, prev_byte} != lag_n) begin
					st = ST_CRC_BAD;
				end else if (hdr || pos < 8'd2) begin
					st = ST_HEADER_BAD;
				end else if (int'(pos) != 4 + 2 * int'(regs.register_count)) begin
					st = ST_LENGTH_BAD;
				end else begin
					st = ST_OK;
				end
				r = '{result_kind: KIND_STATUS, word_index: 7'd0, word_value: 16'd0,
					status: st, last: 1'b1};
				due_outputs.push_back(r);
				clear_frame();
				return;
			end
			if (pos >= 8'd4 && !pos[0]) begin
				k = (pos - 8'd4) >> 1;
				if (k < {1'b0, regs.register_count}) begin
					r = '{result_kind: KIND_WORD, word_index: k[6:0],
						word_value: {prev_byte, item.rx_byte}, status: ST_OK, last: 1'b0};
					due_outputs.push_back(r);
				end
			end
			crc_lag   = lag_n;
			crc_cur   = cur_n;
			hdr_bad   = hdr;
			prev_byte = item.rx_byte;
			if (pos != POS_MAX) begin
				pos = pos + 8'd1;
			end
		endfunction

		task report(input string field, input int unsigned got, input int unsigned want);
			errors++;
			$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		endtask

		task check_output(input out_t got);
			out_t want;
			if (due_outputs.size() == 0) begin
				report("result with none expected", got, 0);
				return;
			end
			want = due_outputs.pop_front();
			if (got.result_kind !== want.result_kind) begin
				report("result_kind", got.result_kind, want.result_kind);
			end
			if (got.word_index !== want.word_index) begin
				report("word_index", got.word_index, want.word_index);
			end
			if (got.word_value !== want.word_value) begin
				report("word_value", got.word_value, want.word_value);
			end
			if (got.status !== want.status) begin
				report("status", got.status, want.status);
			end
			if (got.last !== want.last) begin
				report("last", got.last, want.last);
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_ready;
	in_t                  byte_data;
	logic                 result_valid;
	logic                 result_ready;
	out_t                 result_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	rtu_reply_scoreboard sb = new();

	bit          idle_on;
	int          quiet_cycles;
	int unsigned phase_bytes;
	logic [7:0]  frame_q[$];

	modbus_rtu_read_response_checker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_output(result_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && byte_ready) || (result_valid && result_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// result side stalls in bursts
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	task automatic send_byte(input in_t item);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= item;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		sb.note_byte(item);
		phase_bytes++;
	endtask

	task automatic wait_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic send_frame_q(input bit add_crc, input logic [15:0] crc_flip,
			input int pause_at);
		logic [15:0] crc;
		in_t         item;
		if (add_crc) begin
			crc = 16'hFFFF;
			foreach (frame_q[j]) begin
				crc = sb.crc_next(crc, frame_q[j]);
			end
			crc = crc ^ crc_flip;
			frame_q.push_back(crc[7:0]);
			frame_q.push_back(crc[15:8]);
		end
		for (int i = 0; i < frame_q.size(); i++) begin
			item.rx_byte      = frame_q[i];
			item.end_of_frame = (i == frame_q.size() - 1);
			send_byte(item);
			if (i == pause_at) begin
				wait_results();
			end
		end
	endtask

	task automatic send_random_frame(input frame_shape_e shape, input int pause_at);
		int unsigned data_len;
		int unsigned hdr_idx;
		logic [15:0] flip;
		frame_q  = {};
		flip     = 16'd0;
		data_len = 2 * sb.regs.register_count;
		case (shape)
			FR_NOISE: begin
				repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
			end
			FR_HUGE: begin
				repeat ($urandom_range(255, 268)) frame_q.push_back(8'($urandom));
			end
			default: begin
				if (shape == FR_BAD_LENGTH) begin
					data_len = $urandom_range(0, 2 * sb.regs.register_count + 5);
					if (data_len >= 2 * sb.regs.register_count) begin
						data_len++;
					end
				end
				frame_q.push_back(sb.regs.slave_address);
				frame_q.push_back(sb.regs.function_code);
				frame_q.push_back({sb.regs.register_count, 1'b0});
				if (shape == FR_BAD_HEADER) begin
					hdr_idx = $urandom_range(0, 2);
					frame_q[hdr_idx] = frame_q[hdr_idx] ^ 8'($urandom_range(1, 255));
				end
				repeat (data_len) frame_q.push_back(8'($urandom));
				if (shape == FR_BAD_CRC) begin
					flip = 16'($urandom_range(1, 65535));
				end
			end
		endcase
		send_frame_q(shape != FR_NOISE, flip, pause_at);
	endtask

	initial begin
		frame_shape_e shape;
		int unsigned  pick;
		logic [7:0]   addr;
		logic [7:0]   func;
		logic [6:0]   count;
		bit           first;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		byte_data    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_SLAVE_ADDRESS;
		cfg_data     = 8'd0;
		idle_on      = 1'b1;
		quiet_cycles = 0;
		phase_bytes  = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte, empty crc good and bad, good reply, bad address
		frame_q = '{8'hFF};
		send_frame_q(1'b0, 16'd0, -1);
		frame_q = '{8'hFF, 8'hFF};
		send_frame_q(1'b0, 16'd0, -1);
		frame_q = '{8'h00, 8'h00};
		send_frame_q(1'b0, 16'd0, -1);
		frame_q = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'h00};
		send_frame_q(1'b1, 16'd0, -1);
		frame_q = '{8'h00, 8'h03, 8'h02, 8'h12, 8'h34};
		send_frame_q(1'b1, 16'd0, -1);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					addr  = 8'h00;
					func  = 8'h00;
					count = 7'd0;
				end
				1: begin
					addr  = 8'hFF;
					func  = 8'hFF;
					count = 7'd127;
				end
				2: begin
					addr  = 8'h5A;
					func  = 8'h03;
					count = 7'd125;
				end
				3: begin
					addr  = 8'($urandom);
					func  = 8'($urandom);
					count = 7'd126;
				end
				default: begin
					addr  = 8'($urandom);
					func  = 8'($urandom);
					count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(10, 40))
						: 7'($urandom_range(0, 6));
				end
			endcase
			write_reg(CFG_SLAVE_ADDRESS, addr);
			write_reg(CFG_FUNCTION_CODE, func);
			write_reg(CFG_REGISTER_COUNT, {1'b0, count});
			cfg_valid <= 1'b0;
			idle_on     = (phase < 10) && (phase % 3 != 2);
			phase_bytes = 0;
			first       = 1'b1;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					shape = FR_GOOD;
				end else if (pick < 65) begin
					shape = FR_BAD_CRC;
				end else if (pick < 75) begin
					shape = FR_BAD_HEADER;
				end else if (pick < 87) begin
					shape = FR_BAD_LENGTH;
				end else begin
					shape = FR_NOISE;
				end
				if (first && phase == 5) begin
					shape = FR_HUGE;
				end
				send_random_frame(shape, (first && phase == 4) ? 3 : -1);
				first = 1'b0;
			end
			wait_results();
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		wait_results();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report("results never received", sb.pending(), 0);
		end
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/mbrc_pkg.sv
rtl/core/mbrc_frame_core.sv
rtl/core/modbus_rtu_read_response_checker_top.sv
dv/tb_modbus_rtu_read_response_checker_top.sv
